// ----- hdl/ttc_pkg.sv -----
// Package for the transposition table cluster: request/response types,
// stored entry layouts, codes and constants. No dependencies.
package ttc_pkg;

  localparam int unsigned DefClusterCount = 1024;
  localparam int unsigned DefWays         = 3;
  localparam logic [7:0]  GenMask         = 8'hFC;
  localparam logic [8:0]  DepthMargin     = 9'd4;

  typedef enum logic {
    OP_PROBE = 1'b0,
    OP_SAVE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BOUND_NONE  = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_BOTH  = 2'd3
  } bound_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_EVAL
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [63:0]        position_key;
    logic [1:0]         target_way;
    logic signed [15:0] new_value;
    logic [1:0]         new_bound;
    logic signed [7:0]  new_depth;
    logic [15:0]        new_move;
    logic signed [15:0] new_eval;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         chosen_way;
    logic signed [15:0] stored_value;
    logic signed [15:0] stored_eval;
    logic signed [7:0]  stored_depth;
    logic [15:0]        stored_move;
    logic [7:0]         stored_gen_bound;
  } rsp_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] move;
  } tm_t;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] eval;
    logic [7:0]  depth;
    logic [7:0]  gen_bound;
  } pl_t;

endpackage

// ----- hdl/ttc_store.sv -----
// Cluster store: tag/move and payload memories, one cluster row per address.
// One registered read port and one write port. Depends on ttc_pkg.
module ttc_store #(
  parameter int unsigned CLUSTER_COUNT = ttc_pkg::DefClusterCount,
  parameter int unsigned WAYS          = ttc_pkg::DefWays,
  localparam int unsigned IdxW = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [IdxW-1:0]              rd_addr_i,
  output ttc_pkg::tm_t [WAYS-1:0]      rd_tm_o,
  output ttc_pkg::pl_t [WAYS-1:0]      rd_pl_o,
  input  logic                         wr_en_i,
  input  logic [IdxW-1:0]              wr_addr_i,
  input  ttc_pkg::tm_t [WAYS-1:0]      wr_tm_i,
  input  ttc_pkg::pl_t [WAYS-1:0]      wr_pl_i
);

  ttc_pkg::tm_t [WAYS-1:0] tm_mem [CLUSTER_COUNT];
  ttc_pkg::pl_t [WAYS-1:0] pl_mem [CLUSTER_COUNT];
  ttc_pkg::tm_t [WAYS-1:0] rd_tm_q;
  ttc_pkg::pl_t [WAYS-1:0] rd_pl_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tm_mem[wr_addr_i] <= wr_tm_i;
      pl_mem[wr_addr_i] <= wr_pl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_tm_q <= tm_mem[rd_addr_i];
      rd_pl_q <= pl_mem[rd_addr_i];
    end
  end

  assign rd_tm_o = rd_tm_q;
  assign rd_pl_o = rd_pl_q;

endmodule

// ----- hdl/transposition_table_cluster.sv -----
// Transposition table cluster top level: request FSM, cluster index,
// probe/save evaluation and output register. Depends on ttc_pkg, ttc_store.
//
//   channel | signals                            | payload
//   in      | in_valid_i  / in_ready_o           | in_req_i   (ttc_pkg::req_t)
//   out     | out_valid_o / out_ready_i          | out_rsp_o  (ttc_pkg::rsp_t)
//   cfg     | cfg_valid_i / cfg_ready_o          | cfg_data_i (search generation)
//
// A request passes through ST_IDLE (accepting), ST_MUL_LO and ST_MUL_HI for the
// cluster index multiply (low, then high half of the key, the row read issued
// with the high half) and ST_EVAL to evaluate, write back and load the response
// register, which drives out_rsp_o with out_valid_o set.
// After reset a clearing pass zeroes one cluster row per cycle, all
// CLUSTER_COUNT rows, with in_ready_o low; cfg writes are taken at any time.
// A held response stalls the evaluate step; the next request is taken as
// soon as the previous one has reached the response register.
module transposition_table_cluster #(
  parameter int unsigned CLUSTER_COUNT = ttc_pkg::DefClusterCount,
  parameter int unsigned WAYS          = ttc_pkg::DefWays
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ttc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ttc_pkg::rsp_t out_rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_data_i
);

  localparam int unsigned IdxW = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
  localparam int unsigned CntW = $clog2(CLUSTER_COUNT + 1);
  localparam int unsigned LoW  = 32 + CntW;
  localparam int unsigned HiW  = 33 + CntW;

  ttc_pkg::state_e state_q, state_d;
  ttc_pkg::req_t   req_q;
  ttc_pkg::rsp_t   rsp_q, rsp_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      gen_q;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] carry_q;
  logic [LoW-1:0]  lo_prod;
  logic [HiW-1:0]  hi_sum;

  logic                    rd_en;
  logic                    wr_en;
  logic [IdxW-1:0]         wr_addr;
  ttc_pkg::tm_t [WAYS-1:0] rd_tm, wr_tm, sv_tm;
  ttc_pkg::pl_t [WAYS-1:0] rd_pl, wr_pl, sv_pl;
  logic                    load_out;
  logic                    save_ok;
  ttc_pkg::rsp_t           eval_rsp;

  assign lo_prod = LoW'(req_q.position_key[31:0]) * LoW'(CLUSTER_COUNT);
  assign hi_sum  = HiW'(req_q.position_key[63:32]) * HiW'(CLUSTER_COUNT) + HiW'(carry_q);
  assign idx_d   = hi_sum[32 +: IdxW];

  // probe and save evaluation on the row just read
  always_comb begin
    logic [15:0]       k16;
    logic              found;
    logic [1:0]        hit_way;
    logic [1:0]        best;
    logic signed [9:0] score [WAYS];
    logic signed [9:0] best_score;
    logic [7:0]        age;
    logic              same;
    logic              overwrite;
    ttc_pkg::tm_t      ntm;
    ttc_pkg::pl_t      npl;
    ttc_pkg::tm_t      sel_tm;
    ttc_pkg::pl_t      sel_pl;

    k16        = req_q.position_key[15:0];
    found      = 1'b0;
    hit_way    = '0;
    best       = '0;
    best_score = '0;
    age        = '0;
    same       = 1'b0;
    overwrite  = 1'b0;
    ntm        = '0;
    npl        = '0;
    sel_tm     = '0;
    sel_pl     = '0;
    sv_tm      = rd_tm;
    sv_pl      = rd_pl;
    eval_rsp   = '0;
    save_ok    = ({1'b0, req_q.target_way} < 3'(WAYS));

    for (int i = 0; i < WAYS; i++) begin
      age      = gen_q - (rd_pl[i].gen_bound & ttc_pkg::GenMask);
      score[i] = 10'($signed(rd_pl[i].depth)) - $signed({2'b00, age});
    end

    if (req_q.op == ttc_pkg::OP_PROBE) begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (rd_tm[i].tag == k16 && rd_pl[i].gen_bound != 8'h00) begin
          found   = 1'b1;
          hit_way = 2'(i);
        end
      end
      best_score = score[0];
      for (int i = 1; i < WAYS; i++) begin
        if (best_score > score[i]) begin
          best       = 2'(i);
          best_score = score[i];
        end
      end
      for (int i = 0; i < WAYS; i++) begin
        if (2'(i) == (found ? hit_way : best)) begin
          sel_tm = rd_tm[i];
          sel_pl = rd_pl[i];
        end
      end
      eval_rsp.hit        = found;
      eval_rsp.chosen_way = found ? hit_way : best;
    end else begin
      for (int i = 0; i < WAYS; i++) begin
        if (2'(i) == req_q.target_way) begin
          same      = (rd_tm[i].tag == k16);
          overwrite = (req_q.new_bound == ttc_pkg::BOUND_BOTH) || !same ||
                      ($signed({req_q.new_depth[7], req_q.new_depth}) +
                       $signed(ttc_pkg::DepthMargin) >
                       $signed({rd_pl[i].depth[7], rd_pl[i].depth}));
          ntm.tag   = k16;
          ntm.move  = (req_q.new_move != 16'h0000 || !same) ? req_q.new_move
                                                              : rd_tm[i].move;
          npl       = rd_pl[i];
          if (overwrite) begin
            npl.value     = req_q.new_value;
            npl.eval      = req_q.new_eval;
            npl.depth     = req_q.new_depth;
            npl.gen_bound = gen_q | {6'b000000, req_q.new_bound};
          end
          sv_tm[i] = ntm;
          sv_pl[i] = npl;
          sel_tm   = ntm;
          sel_pl   = npl;
        end
      end
      eval_rsp.hit        = 1'b0;
      eval_rsp.chosen_way = req_q.target_way;
    end

    eval_rsp.stored_value     = sel_pl.value;
    eval_rsp.stored_eval      = sel_pl.eval;
    eval_rsp.stored_depth     = sel_pl.depth;
    eval_rsp.stored_move      = sel_tm.move;
    eval_rsp.stored_gen_bound = sel_pl.gen_bound;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_tm       = sv_tm;
    wr_pl       = sv_pl;
    load_out    = 1'b0;
    rsp_d       = rsp_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ttc_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_tm   = '0;
        wr_pl   = '0;
        clr_d   = clr_q + IdxW'(1);
        if (clr_q == IdxW'(CLUSTER_COUNT - 1)) begin
          state_d = ttc_pkg::ST_IDLE;
        end
      end
      ttc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ttc_pkg::ST_MUL_LO;
        end
      end
      ttc_pkg::ST_MUL_LO: begin
        state_d = ttc_pkg::ST_MUL_HI;
      end
      ttc_pkg::ST_MUL_HI: begin
        rd_en   = 1'b1;
        state_d = ttc_pkg::ST_EVAL;
      end
      ttc_pkg::ST_EVAL: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          rsp_d    = eval_rsp;
          wr_en    = (req_q.op == ttc_pkg::OP_SAVE) && save_ok;
          state_d  = ttc_pkg::ST_IDLE;
        end
      end
      default: state_d = ttc_pkg::ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttc_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      gen_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        gen_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (state_q == ttc_pkg::ST_MUL_LO) begin
      carry_q <= lo_prod[32 +: CntW];
    end
    if (state_q == ttc_pkg::ST_MUL_HI) begin
      idx_q <= idx_d;
    end
    rsp_q <= rsp_d;
  end

  ttc_store #(
    .CLUSTER_COUNT(CLUSTER_COUNT),
    .WAYS         (WAYS)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(idx_d),
    .rd_tm_o  (rd_tm),
    .rd_pl_o  (rd_pl),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_tm_i  (wr_tm),
    .wr_pl_i  (wr_pl)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_wr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ttc_pkg::ST_CLEAR || state_q == ttc_pkg::ST_EVAL))
    else $error("store write outside clear or evaluate");

  a_rd_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == ttc_pkg::ST_EVAL))
    else $error("row read not followed by evaluate");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ttc_pkg::ST_MUL_LO))
    else $error("accepted request did not start index computation");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ttc_pkg::ST_EVAL))
    else $error("response loaded outside evaluate");

  a_no_save_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && req_q.op == ttc_pkg::OP_SAVE) |=> !rsp_q.hit)
    else $error("save reported a hit");

endmodule
